[rtl/core/kfs_pkg.sv]
// ----------------------------------------------------------------------------
// kfs_pkg: shared definitions for the k-th free slot select/remove unit
// Field widths, register reset value and the status bundle of the tree fill.
// ----------------------------------------------------------------------------
package kfs_pkg;

  // Request and result field widths
  localparam int RANK_W = 11;
  localparam int POS_W  = 11;
  localparam int CNT_W  = 11;

  // Slot count register reset value
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  // Status of the tree fill sweep
  typedef struct packed {
    logic busy;
    logic last;
  } kfs_fill_stat_t;

endpackage

[rtl/core/kfs_if.sv]
// ----------------------------------------------------------------------------
// kfs_in_if / kfs_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kfs_in_if import kfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_k;
  logic              refill;

  modport source (output valid, output rank_k, output refill, input ready);
  modport sink   (input valid, input rank_k, input refill, output ready);
endinterface

interface kfs_out_if import kfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             error;

  modport source (output valid, output position, output error, input ready);
  modport sink   (input valid, input position, input error, output ready);
endinterface

[rtl/core/kfs_ram.sv]
// ----------------------------------------------------------------------------
// kfs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfs_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/kfs_fill.sv]
// ----------------------------------------------------------------------------
// kfs_fill: tree refill sweep
// Walks every node of the count tree in index order, one node a cycle, and
// produces the count that a tree holding slots 1..n present gives that node.
// ----------------------------------------------------------------------------
module kfs_fill import kfs_pkg::*; #(
  parameter int LEVELS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [LEVELS:0]     n,
  output kfs_fill_stat_t      stat,
  output logic [LEVELS:0]     addr,
  output logic [LEVELS:0]     data
);

  localparam logic [LEVELS:0] LEAF_SPAN = {1'b1, {LEVELS{1'b0}}};

  logic            busy_r, busy_nxt;
  logic [LEVELS:0] node_r, node_nxt;
  logic [LEVELS:0] base_r, base_nxt;   // first leaf under the node
  logic [LEVELS:0] span_r, span_nxt;   // leaves under the node
  logic [LEVELS:0] base_sum;
  logic            last;

  assign last     = (node_r == {(LEVELS+1){1'b1}});
  assign base_sum = base_r + span_r;

  // Advance node, leaf base and span; restart at node 1 on start
  always_comb begin
    busy_nxt = busy_r;
    node_nxt = node_r;
    base_nxt = base_r;
    span_nxt = span_r;
    if (start) begin
      busy_nxt = 1'b1;
      node_nxt = (LEVELS+1)'(1);
      base_nxt = '0;
      span_nxt = LEAF_SPAN;
    end else if (busy_r) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        node_nxt = node_r + (LEVELS+1)'(1);
        if (base_sum == LEAF_SPAN) begin
          base_nxt = '0;
          span_nxt = span_r >> 1;
        end else begin
          base_nxt = base_sum;
        end
      end
    end
  end

  // Reset starts a sweep at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      node_r <= (LEVELS+1)'(1);
      base_r <= '0;
      span_r <= LEAF_SPAN;
    end else begin
      busy_r <= busy_nxt;
      node_r <= node_nxt;
      base_r <= base_nxt;
      span_r <= span_nxt;
    end
  end

  // Count of present leaves under the node: clamp(n - base, 0, span)
  always_comb begin
    if (n > base_r) begin
      data = ((n - base_r) > span_r) ? span_r : (n - base_r);
    end else begin
      data = '0;
    end
  end

  assign addr      = node_r;
  assign stat.busy = busy_r;
  assign stat.last = busy_r & last;

endmodule

[rtl/core/kfs_alu.sv]
// ----------------------------------------------------------------------------
// kfs_alu: shared compare/subtract step of the tree walk
// Compares the rank with the left child count, picks the branch and gives the
// remaining rank and the chosen child's count before and after removal.
// ----------------------------------------------------------------------------
module kfs_alu import kfs_pkg::*; #(
  parameter int CW   = 11,
  parameter int CMPW = 11
) (
  input  logic [CMPW-1:0] k,
  input  logic [CW-1:0]   left,
  input  logic [CW-1:0]   cur,
  output logic            go_right,
  output logic [CMPW-1:0] k_next,
  output logic [CW-1:0]   child_cnt,
  output logic [CW-1:0]   child_dec
);

  logic [CMPW-1:0] left_x;

  assign left_x    = CMPW'(left);
  assign go_right  = (left_x < k);
  assign k_next    = go_right ? (k - left_x) : k;
  assign child_cnt = go_right ? (cur - left) : left;
  assign child_dec = child_cnt - CW'(1);

endmodule

[rtl/core/kth_free_slot_select_remove_unit.sv]
// ----------------------------------------------------------------------------
// kth_free_slot_select_remove_unit: k-th present slot select and remove
// Slots 1..SLOTS are kept as a power-of-two binary tree of counts in one RAM.
// A request with rank k walks from the root to the k-th present slot, removes
// it and returns its number; a zero or too large rank returns position 0 with
// error set and removes nothing. With refill set, slots 1..min(slot_count,
// SLOTS) are made present before the selection; a slot_count write only takes
// effect at the next refill. The tree has L = clog2(SLOTS) levels below the root
// (10 at the default). An accepted request first compares its rank with the
// root count, which is read while idle, then walks down one tree level per
// step, where the RAM read of the left child feeds the shared compare/subtract
// unit while the decremented count of the chosen child is written back, and
// then loads the result register, waiting while an earlier result is not yet
// taken. The block is ready again once the result register is loaded and takes
// no new request before then. A refill adds a sweep that rewrites every node
// once, then a read of the new root. The same sweep runs after reset; no
// request is accepted until it ends. The result register lets a new request be
// taken while a result waits.
// ----------------------------------------------------------------------------
module kth_free_slot_select_remove_unit import kfs_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  kfs_in_if.sink           in_ch,
  kfs_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int LW    = $clog2(SLOTS);
  localparam int AW    = LW + 1;
  localparam int CW    = LW + 1;
  localparam int CMPW  = (CW > RANK_W) ? CW : RANK_W;
  localparam int PXW   = ((LW + 1) > POS_W) ? (LW + 1) : POS_W;
  localparam int RST_N = (int'(SLOT_COUNT_RST) < SLOTS) ? int'(SLOT_COUNT_RST) : SLOTS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SWEEP = 6'b000010,
    ST_ROOT  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] slot_count_r;
  logic [CW-1:0]    fill_n_r, fill_n_nxt;
  logic             item_r, item_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [CMPW-1:0]  k_r, k_nxt;
  logic [CW-1:0]    cur_r, cur_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             res_err_r, res_err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_err_r, out_err_nxt;

  logic             accept;
  logic             fill_start;
  kfs_fill_stat_t   fill_stat;
  logic [AW-1:0]    fill_addr;
  logic [CW-1:0]    fill_data;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [CW-1:0]    ram_rdata;

  logic [CMPW-1:0]  alu_k;
  logic [CW-1:0]    alu_cur;
  logic             go_right;
  logic [CMPW-1:0]  k_next;
  logic [CW-1:0]    child_cnt;
  logic [CW-1:0]    child_dec;
  logic [AW-1:0]    child;
  logic [PXW-1:0]   pos_wide;
  logic [CW-1:0]    refill_n;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid & in_ch.ready;
  assign fill_start  = accept & in_ch.refill;

  // Saturate the refill count at the tree size
  assign refill_n = (int'(slot_count_r) > SLOTS) ? CW'(SLOTS) : CW'(slot_count_r);

  // Hold the slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  kfs_fill #(
    .LEVELS (LW)
  ) u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fill_start),
    .n     (fill_n_r),
    .stat  (fill_stat),
    .addr  (fill_addr),
    .data  (fill_data)
  );

  kfs_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** AW)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The root check feeds the root count as both left and current count
  assign alu_k   = k_r;
  assign alu_cur = (state_r == ST_CHECK) ? ram_rdata : cur_r;

  kfs_alu #(
    .CW   (CW),
    .CMPW (CMPW)
  ) u_alu (
    .k         (alu_k),
    .left      (ram_rdata),
    .cur       (alu_cur),
    .go_right  (go_right),
    .k_next    (k_next),
    .child_cnt (child_cnt),
    .child_dec (child_dec)
  );

  assign child    = {node_r[AW-2:0], go_right};
  assign pos_wide = PXW'(child[LW-1:0]) + PXW'(1);

  // Sequencer and walk datapath
  always_comb begin
    state_nxt     = state_r;
    fill_n_nxt    = fill_n_r;
    item_nxt      = item_r;
    node_nxt      = node_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    res_pos_nxt   = res_pos_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_addr;
    ram_wdata     = fill_data;
    ram_raddr     = AW'(1);

    // Drop the result once taken
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // Root is read every idle cycle for the check that follows
        if (accept) begin
          k_nxt = CMPW'(in_ch.rank_k);
          if (in_ch.refill) begin
            fill_n_nxt = refill_n;
            item_nxt   = 1'b1;
            state_nxt  = ST_SWEEP;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_SWEEP: begin
        ram_we = fill_stat.busy;
        if (fill_stat.last) begin
          state_nxt = item_r ? ST_ROOT : ST_IDLE;
          item_nxt  = 1'b0;
        end
      end
      ST_ROOT: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if ((k_r == '0) || go_right) begin
          res_pos_nxt = '0;
          res_err_nxt = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          // Remove from the root and start at its left child
          ram_we    = 1'b1;
          ram_waddr = AW'(1);
          ram_wdata = child_dec;
          ram_raddr = AW'(2);
          node_nxt  = AW'(1);
          cur_nxt   = ram_rdata;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // Remove from the chosen child and read its left child
        ram_we    = 1'b1;
        ram_waddr = child;
        ram_wdata = child_dec;
        ram_raddr = {child[AW-2:0], 1'b0};
        k_nxt     = k_next;
        cur_nxt   = child_cnt;
        node_nxt  = child;
        if (child[AW-1]) begin
          res_pos_nxt = pos_wide[POS_W-1:0];
          res_err_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = res_pos_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      item_r      <= 1'b0;
      fill_n_r    <= CW'(RST_N);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      fill_n_r    <= fill_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    res_pos_r <= res_pos_nxt;
    res_err_r <= res_err_nxt;
    out_pos_r <= out_pos_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.error    = out_err_r;

endmodule
